@@ src/eszc_pkg.sv @@
// Shared types and constants of the encoder still-zero calibration core.
// No dependencies; all other files reference it by scoped names.
package eszc_pkg;

  localparam int SAMPLE_TARGET   = 100;
  localparam int CNT_W           = 7;
  localparam int ANGLE_W         = 13;
  localparam int COUNTS_PER_TURN = 8192;
  localparam int HALF_TURN       = COUNTS_PER_TURN / 2;
  localparam int SPEED_W         = 16;
  localparam int LIMIT_W         = 15;
  localparam int SPAN_W          = 13;
  localparam int SEQ_W           = 32;
  localparam int UNW_W           = 15;
  localparam int SUM_W           = 22;
  localparam int ROUND_HALF      = SAMPLE_TARGET / 2;
  localparam int RECIP_SH        = 28;
  localparam int RECIP_M         = ((1 << RECIP_SH) + SAMPLE_TARGET - 1) / SAMPLE_TARGET;
  localparam int RECIP_W         = 22;
  localparam int QUOT_W          = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 15;

  localparam logic [CFG_IDX_W-1:0] REG_STILL_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPAN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USE_FIXED   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_ZERO  = 2'd3;

  localparam logic [LIMIT_W-1:0] STILL_LIMIT_RST = 15'd2;
  localparam logic [SPAN_W-1:0]  MAX_SPAN_RST    = 13'd64;

  typedef enum logic [1:0] {
    ST_WAIT_FEEDBACK = 2'd0,
    ST_WAIT_STILL    = 2'd1,
    ST_SAMPLING      = 2'd2,
    ST_CALIBRATED    = 2'd3
  } cal_status_t;

  typedef struct packed {
    logic                      online;
    logic signed [SPEED_W-1:0] rotor_speed;
    logic [ANGLE_W-1:0]        angle;
    logic [SEQ_W-1:0]          frame_seq;
  } frame_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] still_limit;
    logic [SPAN_W-1:0]  max_span;
    logic               use_fixed;
    logic [ANGLE_W-1:0] fixed_zero;
  } cfg_t;

  typedef struct packed {
    cal_status_t             status;
    logic [CNT_W-1:0]        samples;
    logic                    cal_now;
    logic signed [SUM_W-1:0] sum;
  } track_t;

endpackage

@@ src/eszc_track.sv @@
// Calibration run tracker: run state registers and the per-frame update.
// Depends on eszc_pkg.
module eszc_track (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  eszc_pkg::frame_t frame,
  input  eszc_pkg::cfg_t   cfg,
  output eszc_pkg::track_t upd
);

  eszc_pkg::cal_status_t                status_r, status_nxt;
  logic [eszc_pkg::SEQ_W-1:0]           last_seq_r, last_seq_nxt;
  logic [eszc_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                                 ref_valid_r, ref_valid_nxt;
  logic [eszc_pkg::ANGLE_W-1:0]         ref_angle_r, ref_angle_nxt;
  logic signed [eszc_pkg::UNW_W-1:0]    min_r, min_nxt;
  logic signed [eszc_pkg::UNW_W-1:0]    max_r, max_nxt;
  logic signed [eszc_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic                                 cal_now;

  always_comb begin
    logic [eszc_pkg::SPEED_W:0]          spd_abs;
    logic                                moving;
    logic [eszc_pkg::ANGLE_W-1:0]        ref_a;
    logic signed [eszc_pkg::UNW_W-1:0]   mn, mx, delta, unw;
    logic signed [eszc_pkg::UNW_W:0]     span;
    spd_abs = frame.rotor_speed[eszc_pkg::SPEED_W-1]
            ? (eszc_pkg::SPEED_W+1)'(-{frame.rotor_speed[eszc_pkg::SPEED_W-1], frame.rotor_speed})
            : (eszc_pkg::SPEED_W+1)'({1'b0, frame.rotor_speed});
    moving  = spd_abs > (eszc_pkg::SPEED_W+1)'(cfg.still_limit);
    ref_a   = ref_valid_r ? ref_angle_r : frame.angle;
    mn      = ref_valid_r ? min_r : eszc_pkg::UNW_W'(frame.angle);
    mx      = ref_valid_r ? max_r : eszc_pkg::UNW_W'(frame.angle);
    delta   = eszc_pkg::UNW_W'(frame.angle) - eszc_pkg::UNW_W'(ref_a);
    if (delta > eszc_pkg::UNW_W'(eszc_pkg::HALF_TURN)) begin
      delta = delta - eszc_pkg::UNW_W'(eszc_pkg::COUNTS_PER_TURN);
    end else if (delta < -eszc_pkg::UNW_W'(eszc_pkg::HALF_TURN)) begin
      delta = delta + eszc_pkg::UNW_W'(eszc_pkg::COUNTS_PER_TURN);
    end
    unw = eszc_pkg::UNW_W'(ref_a) + delta;
    if (unw < mn) mn = unw;
    if (unw > mx) mx = unw;
    span = (eszc_pkg::UNW_W+1)'(mx) - (eszc_pkg::UNW_W+1)'(mn);

    status_nxt    = status_r;
    last_seq_nxt  = last_seq_r;
    cnt_nxt       = cnt_r;
    ref_valid_nxt = ref_valid_r;
    ref_angle_nxt = ref_angle_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    cal_now       = 1'b0;

    if (status_r != eszc_pkg::ST_CALIBRATED) begin
      if (!frame.online || moving) begin
        status_nxt    = frame.online ? eszc_pkg::ST_WAIT_STILL : eszc_pkg::ST_WAIT_FEEDBACK;
        last_seq_nxt  = frame.frame_seq;
        cnt_nxt       = '0;
        ref_valid_nxt = 1'b0;
        sum_nxt       = '0;
      end else begin
        status_nxt = eszc_pkg::ST_SAMPLING;
        if (cnt_r < eszc_pkg::CNT_W'(eszc_pkg::SAMPLE_TARGET) &&
            frame.frame_seq != last_seq_r) begin
          last_seq_nxt  = frame.frame_seq;
          ref_angle_nxt = ref_a;
          min_nxt       = mn;
          max_nxt       = mx;
          if (span > (eszc_pkg::UNW_W+1)'(cfg.max_span)) begin
            status_nxt    = eszc_pkg::ST_WAIT_STILL;
            cnt_nxt       = '0;
            ref_valid_nxt = 1'b0;
            sum_nxt       = '0;
          end else begin
            ref_valid_nxt = 1'b1;
            sum_nxt       = sum_r + eszc_pkg::SUM_W'(unw);
            cnt_nxt       = cnt_r + 1'b1;
          end
        end
        if (status_nxt == eszc_pkg::ST_SAMPLING &&
            cnt_nxt >= eszc_pkg::CNT_W'(eszc_pkg::SAMPLE_TARGET)) begin
          status_nxt = eszc_pkg::ST_CALIBRATED;
          cal_now    = 1'b1;
        end
      end
    end

    upd.status  = status_nxt;
    upd.samples = cnt_nxt;
    upd.cal_now = cal_now;
    upd.sum     = sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= eszc_pkg::ST_WAIT_FEEDBACK;
      last_seq_r  <= '0;
      cnt_r       <= '0;
      ref_valid_r <= 1'b0;
      ref_angle_r <= '0;
      min_r       <= '0;
      max_r       <= '0;
      sum_r       <= '0;
    end else if (step) begin
      status_r    <= status_nxt;
      last_seq_r  <= last_seq_nxt;
      cnt_r       <= cnt_nxt;
      ref_valid_r <= ref_valid_nxt;
      ref_angle_r <= ref_angle_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      sum_r       <= sum_nxt;
    end
  end

endmodule

@@ src/eszc_zero.sv @@
// Zero position unit: rounded average by reciprocal multiply or the fixed zero register, wrap, latch.
// Depends on eszc_pkg.
module eszc_zero (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           latch,
  input  logic                           cal_now,
  input  logic signed [eszc_pkg::SUM_W-1:0] sum,
  input  eszc_pkg::cfg_t                 cfg,
  output logic [eszc_pkg::ANGLE_W-1:0]   zero
);

  logic [eszc_pkg::ANGLE_W-1:0] zero_latched_r;
  logic [eszc_pkg::ANGLE_W-1:0] zero_nxt;

  always_comb begin
    logic                                      neg;
    logic [eszc_pkg::SUM_W-1:0]                mag;
    logic [eszc_pkg::SUM_W+eszc_pkg::RECIP_W-1:0] prod;
    logic [eszc_pkg::QUOT_W-1:0]               quot;
    neg  = sum[eszc_pkg::SUM_W-1];
    mag  = (neg ? eszc_pkg::SUM_W'(-sum) : eszc_pkg::SUM_W'(sum))
         + eszc_pkg::SUM_W'(eszc_pkg::ROUND_HALF);
    prod = (eszc_pkg::SUM_W+eszc_pkg::RECIP_W)'(mag) *
           (eszc_pkg::SUM_W+eszc_pkg::RECIP_W)'(eszc_pkg::RECIP_M);
    quot = prod[eszc_pkg::RECIP_SH +: eszc_pkg::QUOT_W];
    if (cfg.use_fixed) begin
      zero_nxt = cfg.fixed_zero;
    end else if (neg) begin
      zero_nxt = eszc_pkg::ANGLE_W'(-quot);
    end else begin
      zero_nxt = eszc_pkg::ANGLE_W'(quot);
    end
    zero = cal_now ? zero_nxt : zero_latched_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_latched_r <= '0;
    end else if (latch && cal_now) begin
      zero_latched_r <= zero_nxt;
    end
  end

endmodule

@@ src/encoder_still_zero_calibration_core.sv @@
// Top level of the encoder still-zero calibration core: handshakes, config
// registers, pipeline registers. Depends on eszc_pkg, eszc_track, eszc_zero.
//
//   channel | dir | ports
//   in      | in  | in_valid/in_ready, in_online, in_rotor_speed, in_angle, in_frame_seq
//   out     | out | out_valid/out_ready, out_cal_status, out_zero_position, out_samples_taken
//   cfg     | in  | cfg_we, cfg_index, cfg_wdata
//
// One word per cycle sustained while the output is not stalled; a word passes through
// the input register, tracker update and divide/wrap stage on its way to the outputs.
// The run state updates as a word leaves the input register.
// Synchronous active-low reset restores register defaults and empties the pipe.
// A stalled output backs up stage by stage; empty stages keep accepting.
module encoder_still_zero_calibration_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_online,
  input  logic signed [eszc_pkg::SPEED_W-1:0] in_rotor_speed,
  input  logic [eszc_pkg::ANGLE_W-1:0]        in_angle,
  input  logic [eszc_pkg::SEQ_W-1:0]          in_frame_seq,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_cal_status,
  output logic [eszc_pkg::ANGLE_W-1:0]        out_zero_position,
  output logic [eszc_pkg::CNT_W-1:0]          out_samples_taken,
  input  logic                                cfg_we,
  input  logic [eszc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [eszc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  eszc_pkg::cfg_t   cfg_r;
  eszc_pkg::frame_t s1_r;
  eszc_pkg::track_t s2_r;
  eszc_pkg::track_t trk_upd;
  logic             v1_r, v2_r, out_valid_r;
  logic             load1, load2, load3;
  logic [eszc_pkg::ANGLE_W-1:0] zero_val;
  logic [1:0]                   out_status_r;
  logic [eszc_pkg::ANGLE_W-1:0] out_zero_r;
  logic [eszc_pkg::CNT_W-1:0]   out_samples_r;

  assign load3    = !out_valid_r || out_ready;
  assign load2    = !v2_r || load3;
  assign load1    = !v1_r || load2;
  assign in_ready = load1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.still_limit <= eszc_pkg::STILL_LIMIT_RST;
      cfg_r.max_span    <= eszc_pkg::MAX_SPAN_RST;
      cfg_r.use_fixed   <= 1'b0;
      cfg_r.fixed_zero  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        eszc_pkg::REG_STILL_LIMIT: cfg_r.still_limit <= cfg_wdata;
        eszc_pkg::REG_MAX_SPAN:    cfg_r.max_span    <= cfg_wdata[eszc_pkg::SPAN_W-1:0];
        eszc_pkg::REG_USE_FIXED:   cfg_r.use_fixed   <= cfg_wdata[0];
        eszc_pkg::REG_FIXED_ZERO:  cfg_r.fixed_zero  <= cfg_wdata[eszc_pkg::ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load1) v1_r <= in_valid;
      if (load2) v2_r <= v1_r;
      if (load3) out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_r.online      <= in_online;
      s1_r.rotor_speed <= in_rotor_speed;
      s1_r.angle       <= in_angle;
      s1_r.frame_seq   <= in_frame_seq;
    end
    if (load2) begin
      s2_r <= trk_upd;
    end
    if (load3) begin
      out_status_r  <= s2_r.status;
      out_zero_r    <= zero_val;
      out_samples_r <= s2_r.samples;
    end
  end

  eszc_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (v1_r && load2),
    .frame (s1_r),
    .cfg   (cfg_r),
    .upd   (trk_upd)
  );

  eszc_zero u_zero (
    .clk     (clk),
    .rst_n   (rst_n),
    .latch   (v2_r && load3),
    .cal_now (s2_r.cal_now),
    .sum     (s2_r.sum),
    .cfg     (cfg_r),
    .zero    (zero_val)
  );

  assign out_valid         = out_valid_r;
  assign out_cal_status    = out_status_r;
  assign out_zero_position = out_zero_r;
  assign out_samples_taken = out_samples_r;

  a_cal_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cal_status == eszc_pkg::ST_CALIBRATED |->
      out_samples_taken == eszc_pkg::CNT_W'(eszc_pkg::SAMPLE_TARGET))
    else $error("calibrated with short sample count");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_samples_taken <= eszc_pkg::CNT_W'(eszc_pkg::SAMPLE_TARGET))
    else $error("sample count beyond target");

  a_wait_empty: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && (s2_r.status == eszc_pkg::ST_WAIT_FEEDBACK ||
             s2_r.status == eszc_pkg::ST_WAIT_STILL) |-> s2_r.samples == '0)
    else $error("waiting state with samples in run");

  a_cal_now: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && s2_r.cal_now |-> s2_r.status == eszc_pkg::ST_CALIBRATED)
    else $error("zero latch outside calibration step");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for encoder_still_zero_calibration_core: a tracker class
// predicts every status word from the accepted frames and checks results in order.
// Depends on eszc_pkg and the core RTL only.

typedef struct packed {
  eszc_pkg::cal_status_t        status;
  logic [eszc_pkg::ANGLE_W-1:0] zero;
  logic [eszc_pkg::CNT_W-1:0]   samples;
} cal_report_t;

class zero_cal_tracker;
  logic [eszc_pkg::LIMIT_W-1:0] still_limit;
  logic [eszc_pkg::SPAN_W-1:0]  max_span;
  logic                         use_fixed;
  logic [eszc_pkg::ANGLE_W-1:0] fixed_zero;
  eszc_pkg::cal_status_t        status;
  logic [eszc_pkg::SEQ_W-1:0]   last_seq;
  int                           samples;
  bit                           ref_valid;
  int                           ref_angle;
  int                           min_unw;
  int                           max_unw;
  int                           sum_unw;
  logic [eszc_pkg::ANGLE_W-1:0] zero_latched;
  bit                           zero_from_fixed;
  cal_report_t                  pending_reports[$];
  int                           mismatch_cnt;
  int                           report_cnt;

  function new();
    still_limit = eszc_pkg::STILL_LIMIT_RST;
    max_span = eszc_pkg::MAX_SPAN_RST;
    use_fixed = 1'b0;
    fixed_zero = '0;
    status = eszc_pkg::ST_WAIT_FEEDBACK;
    last_seq = '0;
    samples = 0;
    ref_valid = 1'b0;
    ref_angle = 0;
    min_unw = 0;
    max_unw = 0;
    sum_unw = 0;
    zero_latched = '0;
    zero_from_fixed = 1'b0;
    mismatch_cnt = 0;
    report_cnt = 0;
  endfunction

  function void write_reg(logic [eszc_pkg::CFG_IDX_W-1:0] idx,
                          logic [eszc_pkg::CFG_DATA_W-1:0] value);
    case (idx)
      eszc_pkg::REG_STILL_LIMIT: still_limit = value[eszc_pkg::LIMIT_W-1:0];
      eszc_pkg::REG_MAX_SPAN:    max_span = value[eszc_pkg::SPAN_W-1:0];
      eszc_pkg::REG_USE_FIXED:   use_fixed = value[0];
      eszc_pkg::REG_FIXED_ZERO:  fixed_zero = value[eszc_pkg::ANGLE_W-1:0];
      default: ;
    endcase
  endfunction

  function void clear_run(logic [eszc_pkg::SEQ_W-1:0] seq, eszc_pkg::cal_status_t st);
    samples = 0;
    ref_valid = 1'b0;
    sum_unw = 0;
    last_seq = seq;
    status = st;
  endfunction

  function void take_frame(logic online, logic signed [eszc_pkg::SPEED_W-1:0] speed,
                           logic [eszc_pkg::ANGLE_W-1:0] angle,
                           logic [eszc_pkg::SEQ_W-1:0] seq);
    int spd;
    int lim;
    int delta;
    int unw;
    int avg;
    cal_report_t rep;
    spd = int'(speed);
    lim = int'(still_limit);
    if (status != eszc_pkg::ST_CALIBRATED) begin
      if (!online) begin
        clear_run(seq, eszc_pkg::ST_WAIT_FEEDBACK);
      end else if (spd > lim || spd < -lim) begin
        clear_run(seq, eszc_pkg::ST_WAIT_STILL);
      end else begin
        status = eszc_pkg::ST_SAMPLING;
        if (seq != last_seq) begin
          last_seq = seq;
          if (!ref_valid) begin
            ref_angle = int'(angle);
            min_unw = ref_angle;
            max_unw = ref_angle;
            ref_valid = 1'b1;
          end
          delta = int'(angle) - ref_angle;
          if (delta > eszc_pkg::HALF_TURN) begin
            delta -= eszc_pkg::COUNTS_PER_TURN;
          end else if (delta < -eszc_pkg::HALF_TURN) begin
            delta += eszc_pkg::COUNTS_PER_TURN;
          end
          unw = ref_angle + delta;
          if (unw < min_unw) min_unw = unw;
          if (unw > max_unw) max_unw = unw;
          if (max_unw - min_unw > int'(max_span)) begin
            clear_run(seq, eszc_pkg::ST_WAIT_STILL);
          end else begin
            sum_unw += unw;
            samples++;
            if (samples >= eszc_pkg::SAMPLE_TARGET) begin
              zero_from_fixed = use_fixed;
              if (use_fixed) begin
                zero_latched = fixed_zero;
              end else begin
                if (sum_unw >= 0) avg = (sum_unw + eszc_pkg::ROUND_HALF) / eszc_pkg::SAMPLE_TARGET;
                else avg = (sum_unw - eszc_pkg::ROUND_HALF) / eszc_pkg::SAMPLE_TARGET;
                avg = avg % eszc_pkg::COUNTS_PER_TURN;
                if (avg < 0) avg += eszc_pkg::COUNTS_PER_TURN;
                zero_latched = avg[eszc_pkg::ANGLE_W-1:0];
              end
              status = eszc_pkg::ST_CALIBRATED;
            end
          end
        end
      end
    end
    rep.status = status;
    rep.zero = zero_latched;
    rep.samples = samples[eszc_pkg::CNT_W-1:0];
    pending_reports.push_back(rep);
  endfunction

  function void check_report(logic [1:0] st, logic [eszc_pkg::ANGLE_W-1:0] zero,
                             logic [eszc_pkg::CNT_W-1:0] cnt);
    cal_report_t exp_rep;
    report_cnt++;
    if (pending_reports.size() == 0) begin
      $error("unexpected status word: cal_status %0d zero_position %0d samples_taken %0d",
             st, zero, cnt);
      mismatch_cnt++;
      return;
    end
    exp_rep = pending_reports.pop_front();
    if (st !== exp_rep.status) begin
      $error("cal_status: expected %0d, actual %0d", exp_rep.status, st);
      mismatch_cnt++;
    end
    if (zero !== exp_rep.zero) begin
      $error("zero_position: expected %0d, actual %0d", exp_rep.zero, zero);
      mismatch_cnt++;
    end
    if (cnt !== exp_rep.samples) begin
      $error("samples_taken: expected %0d, actual %0d", exp_rep.samples, cnt);
      mismatch_cnt++;
    end
  endfunction
endclass

module tb_top;
  typedef enum int {FR_STILL, FR_REPEAT, FR_MOVING, FR_OFFLINE, FR_FAR, FR_NOISE} frame_kind_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic                                in_online;
  logic signed [eszc_pkg::SPEED_W-1:0] in_rotor_speed;
  logic [eszc_pkg::ANGLE_W-1:0]        in_angle;
  logic [eszc_pkg::SEQ_W-1:0]          in_frame_seq;
  logic                                out_valid;
  logic                                out_ready;
  logic [1:0]                          out_cal_status;
  logic [eszc_pkg::ANGLE_W-1:0]        out_zero_position;
  logic [eszc_pkg::CNT_W-1:0]          out_samples_taken;
  logic                                cfg_we;
  logic [eszc_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [eszc_pkg::CFG_DATA_W-1:0]     cfg_wdata;

  zero_cal_tracker tracker;
  int              frames_sent;
  int              cfg_phases;
  bit              tx_steady;
  bit              rx_steady;
  bit              hold_req;

  encoder_still_zero_calibration_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_online        (in_online),
    .in_rotor_speed   (in_rotor_speed),
    .in_angle         (in_angle),
    .in_frame_seq     (in_frame_seq),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cal_status   (out_cal_status),
    .out_zero_position(out_zero_position),
    .out_samples_taken(out_samples_taken),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, 17);
      if (hold_req) begin
        gap = 200 + $urandom_range(0, 50);
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      tracker.check_report(out_cal_status, out_zero_position, out_samples_taken);
    end
  end

  task automatic send_frame(input logic online, input logic [15:0] speed,
                            input logic [eszc_pkg::ANGLE_W-1:0] angle,
                            input logic [eszc_pkg::SEQ_W-1:0] seq);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_online <= online;
    in_rotor_speed <= speed;
    in_angle <= angle;
    in_frame_seq <= seq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_frame(online, speed, angle, seq);
    frames_sent++;
  endtask

  task automatic send_kind(input frame_kind_t kind, input int center, input int hw);
    int lim;
    int spd;
    int ang;
    logic [31:0] seq;
    lim = int'(tracker.still_limit);
    spd = int'($urandom_range(0, 2 * lim)) - lim;
    ang = center + int'($urandom_range(0, 2 * hw)) - hw;
    do seq = $urandom; while (seq == tracker.last_seq);
    case (kind)
      FR_STILL: send_frame(1'b1, spd[15:0], ang[12:0], seq);
      FR_REPEAT: send_frame(1'b1, spd[15:0], ang[12:0], tracker.last_seq);
      FR_MOVING: begin
        if (lim == 32767) spd = -32768;
        else if ($urandom_range(0, 1)) spd = $urandom_range(lim + 1, 32767);
        else spd = -int'($urandom_range(lim + 1, 32768));
        send_frame(1'b1, spd[15:0], ang[12:0], seq);
      end
      FR_OFFLINE: send_frame(1'b0, 16'($urandom), 13'($urandom), $urandom);
      FR_FAR: begin
        ang = ang + eszc_pkg::HALF_TURN - int'($urandom_range(0, 100));
        send_frame(1'b1, spd[15:0], ang[12:0], seq);
      end
      default: send_frame(1'($urandom), 16'($urandom), 13'($urandom), $urandom);
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [eszc_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[eszc_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    tracker.write_reg(idx, val[eszc_pkg::CFG_DATA_W-1:0]);
  endtask

  task automatic apply_config(input int unsigned limit, input int unsigned span,
                              input int unsigned fixed_sel, input int unsigned fixed_pos);
    write_cfg(eszc_pkg::REG_STILL_LIMIT, limit);
    write_cfg(eszc_pkg::REG_MAX_SPAN, span);
    write_cfg(eszc_pkg::REG_USE_FIXED, fixed_sel);
    write_cfg(eszc_pkg::REG_FIXED_ZERO, fixed_pos);
    cfg_we <= 1'b0;
    cfg_phases++;
  endtask

  task automatic pick_config(input bit wide_span);
    int unsigned limit;
    int unsigned span;
    int unsigned fixed_pos;
    case ($urandom_range(0, 5))
      0: limit = 0;
      1: limit = 32767;
      2: limit = 2;
      3: limit = $urandom_range(1, 40);
      default: limit = $urandom_range(0, 32767);
    endcase
    case ($urandom_range(0, 4))
      0: span = 0;
      1: span = 8191;
      2: span = $urandom_range(1, 64);
      3: span = $urandom_range(65, 600);
      default: span = $urandom_range(0, 8191);
    endcase
    if (wide_span && span < 40) span = $urandom_range(40, 8191);
    case ($urandom_range(0, 2))
      0: fixed_pos = 0;
      1: fixed_pos = 8191;
      default: fixed_pos = $urandom_range(0, 8191);
    endcase
    apply_config(limit, span, wide_span ? ($urandom_range(0, 3) == 0) : $urandom_range(0, 1),
                 fixed_pos);
  endtask

  function automatic int pick_center();
    int c;
    if ($urandom_range(0, 3) == 0) c = int'($urandom_range(0, 31)) - 16;
    else c = $urandom_range(0, 8191);
    return c;
  endfunction

  task automatic random_run();
    int center;
    int hw;
    int len;
    int r;
    center = pick_center();
    hw = int'(tracker.max_span) / 2;
    if (hw > 300) hw = 300;
    if ($urandom_range(0, 9) == 0) hw += 4;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 95) : $urandom_range(1, 30);
    for (int i = 0; i < len && tracker.samples < 90; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5) send_kind(FR_REPEAT, center, hw);
      else if (r < 8) send_kind(FR_NOISE, center, hw);
      else send_kind(FR_STILL, center, hw);
    end
    r = $urandom_range(0, 3);
    if (tracker.samples >= 90) r = r % 2;
    case (r)
      0: send_kind(FR_OFFLINE, center, hw);
      1: send_kind(FR_MOVING, center, hw);
      2: send_kind(FR_FAR, center, hw);
      default: send_kind(FR_NOISE, center, hw);
    endcase
  endtask

  initial begin
    int goal;
    int center;
    tracker = new();
    frames_sent = 0;
    cfg_phases = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_online <= 1'b0;
    in_rotor_speed <= '0;
    in_angle <= '0;
    in_frame_seq <= '0;
    cfg_we <= 1'b0;
    cfg_index <= eszc_pkg::REG_STILL_LIMIT;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_frame(1'b1, 16'sd0, 13'd0, 32'd0);
    send_frame(1'b0, -16'sd32768, 13'd8191, 32'hFFFF_FFFF);
    send_frame(1'b1, -16'sd32768, 13'd10, 32'd1);
    send_frame(1'b1, 16'sd32767, 13'd10, 32'd2);
    send_frame(1'b1, 16'sd2, 13'd8190, 32'd3);
    send_frame(1'b1, -16'sd2, 13'd5, 32'd4);
    send_frame(1'b1, 16'sd0, 13'd5, 32'd4);
    send_frame(1'b1, 16'sd1, 13'd8120, 32'd5);
    settle();
    apply_config(32767, 8191, 1, 8191);
    send_frame(1'b1, 16'sd32767, 13'd0, 32'd6);
    send_frame(1'b1, -16'sd32767, 13'd4096, 32'd7);
    send_frame(1'b1, 16'sd0, 13'd4097, 32'd8);
    send_frame(1'b1, -16'sd32768, 13'd4097, 32'd9);
    settle();
    apply_config(0, 0, 0, 0);
    send_frame(1'b1, 16'sd0, 13'd100, 32'd10);
    send_frame(1'b1, 16'sd1, 13'd100, 32'd11);
    send_frame(1'b1, 16'sd0, 13'd100, 32'd12);
    send_frame(1'b1, 16'sd0, 13'd100, 32'd13);
    send_frame(1'b1, 16'sd0, 13'd101, 32'd14);
    send_frame(1'b0, 16'sd0, 13'd100, 32'd14);
    send_frame(1'b1, 16'sd0, 13'd100, 32'd14);

    for (int p = 0; p < 6; p++) begin
      settle();
      pick_config(1'b0);
      tx_steady = (p == 2) || ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      hold_req = (p == 2);
      goal = frames_sent + 280;
      while (frames_sent < goal) random_run();
    end

    settle();
    pick_config(1'b1);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    center = pick_center();
    send_kind(FR_OFFLINE, center, 16);
    while (tracker.status != eszc_pkg::ST_CALIBRATED) begin
      send_kind(($urandom_range(0, 19) == 0) ? FR_REPEAT : FR_STILL, center, 16);
    end
    for (int i = 0; i < 30; i++) send_kind(frame_kind_t'($urandom_range(0, 5)), center, 16);
    settle();
    pick_config(1'b0);
    for (int i = 0; i < 15; i++) send_kind(frame_kind_t'($urandom_range(0, 5)), center, 16);

    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("summary: %0d frames over %0d register settings, %0d status words checked",
             frames_sent, cfg_phases, tracker.report_cnt);
    $display("summary: final status %0d, zero %0d taken from %s", tracker.status,
             tracker.zero_latched, tracker.zero_from_fixed ? "fixed register" : "average");
    if (tracker.mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
